/* sv/assert_macros.svh */
// Assertion macros shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CLPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CLPS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/clps_pkg.sv */
// Types, codes and constants of the chirp latency probe sequencer.
package clps_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int CHIRP_DEPTH_DEF = 32768;
  localparam int TBL_IDX_BITS    = 15;
  localparam int POS_BITS        = 16;
  localparam int CNT_BITS        = 24;
  localparam int FADE_BITS       = 24;
  localparam int PAUSE_BITS      = 24;
  localparam int LEN_BITS        = 16;
  localparam int CFG_DATA_BITS   = 24;
  localparam int CFG_IDX_BITS    = 2;
  localparam int PHASE_BITS      = 3;

  localparam logic [SAMPLE_BITS-1:0] UNITY_GAIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [FADE_BITS-1:0]  FADE_STEP_RST    = FADE_BITS'(17440);
  localparam logic [PAUSE_BITS-1:0] PAUSE_LEN_RST    = PAUSE_BITS'(24000);
  localparam logic [LEN_BITS-1:0]   CHIRP_LEN_RST    = LEN_BITS'(8192);
  localparam logic [CNT_BITS-1:0]   DETECT_LIMIT_RST = CNT_BITS'(31200);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_LOAD   = 2'd2,
    OP_STOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FADE_STEP    = 2'd0,
    CFG_PAUSE_LEN    = 2'd1,
    CFG_CHIRP_LEN    = 2'd2,
    CFG_DETECT_LIMIT = 2'd3
  } cfg_reg_t;

  // How the output stage forms the sample.
  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_SCALE = 2'd1,
    MODE_ZERO  = 2'd2,
    MODE_TABLE = 2'd3
  } mode_t;

  typedef struct packed {
    op_t                           operation;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [TBL_IDX_BITS-1:0]       table_index;
    logic signed [SAMPLE_BITS-1:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [PHASE_BITS-1:0]         out_phase;
    logic                          detecting;
    logic                          cycle_done;
  } out_item_t;

  // Work handed from the sequencer to the output stage for one sample.
  typedef struct packed {
    mode_t                         mode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0]        gain;
    logic [PHASE_BITS-1:0]         out_phase;
    logic                          detecting;
    logic                          cycle_done;
  } pipe_t;

endpackage

/* sv/clps_table.sv */
// Chirp table: single-port-write, registered-read synchronous memory.
module clps_table
  import clps_pkg::*;
#(
  parameter int CHIRP_DEPTH = CHIRP_DEPTH_DEF,
  localparam int AW = $clog2(CHIRP_DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [SAMPLE_BITS-1:0] rdata
);

  logic [SAMPLE_BITS-1:0] mem [CHIRP_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/clps_ctrl.sv */
// Sequencer state, configuration registers and per-beat state update.
`include "assert_macros.svh"

module clps_ctrl
  import clps_pkg::*;
#(
  parameter int CHIRP_DEPTH = CHIRP_DEPTH_DEF,
  localparam int AW = $clog2(CHIRP_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     accept,
  input  in_item_t                 item,
  output logic                     push,
  output pipe_t                    pipe,
  output logic                     tbl_we,
  output logic [AW-1:0]            tbl_waddr,
  output logic [SAMPLE_BITS-1:0]   tbl_wdata,
  output logic                     tbl_re,
  output logic [AW-1:0]            tbl_raddr
);

  localparam int EXT_BITS = POS_BITS + 1;
  localparam int FO_BITS  = SAMPLE_BITS + 2;
  localparam int FI_BITS  = SAMPLE_BITS + 1;
  localparam logic [EXT_BITS-1:0] DEPTH_EXT = EXT_BITS'(CHIRP_DEPTH);

  typedef enum logic [PHASE_BITS-1:0] {
    PH_BYPASS  = 3'd0,
    PH_FADEOUT = 3'd1,
    PH_PAUSE   = 3'd2,
    PH_EMIT    = 3'd3,
    PH_FADEIN  = 3'd4
  } phase_t;

  logic [FADE_BITS-1:0]   fade_step;
  logic [PAUSE_BITS-1:0]  pause_len;
  logic [LEN_BITS-1:0]    chirp_len;
  logic [CNT_BITS-1:0]    detect_limit;

  phase_t                 phase, phase_next;
  logic                   detect_active, detect_active_next;
  logic                   complete_flag, complete_flag_next;
  logic [SAMPLE_BITS-1:0] gain, gain_next;
  logic [PAUSE_BITS-1:0]  pause_left, pause_left_next;
  logic [POS_BITS-1:0]    emit_pos, emit_pos_next;
  logic [CNT_BITS-1:0]    detect_count, detect_count_next;

  logic [FO_BITS-1:0]     fade_down;
  logic [FI_BITS-1:0]     fade_up;
  logic [EXT_BITS-1:0]    play_lim;
  logic [EXT_BITS-1:0]    pos_ext;
  logic [EXT_BITS-1:0]    idx_ext;
  mode_t                  mode;
  logic                   handled;

  assign fade_down = FO_BITS'(gain) - FO_BITS'(fade_step);
  assign fade_up   = FI_BITS'(gain) + FI_BITS'(fade_step);
  assign play_lim  = (EXT_BITS'(chirp_len) < DEPTH_EXT) ? EXT_BITS'(chirp_len) : DEPTH_EXT;

  assign idx_ext   = EXT_BITS'(item.table_index);
  assign tbl_we    = accept && (item.operation == OP_LOAD) && (idx_ext < DEPTH_EXT);
  assign tbl_waddr = idx_ext[AW-1:0];
  assign tbl_wdata = item.table_value;

  assign push      = accept && (item.operation == OP_SAMPLE);

  // The sample walks through the phases in order; a phase that finishes on
  // this sample hands the same sample to the next phase.
  always_comb begin
    phase_next         = phase;
    detect_active_next = detect_active;
    complete_flag_next = complete_flag;
    gain_next          = gain;
    pause_left_next    = pause_left;
    emit_pos_next      = emit_pos;
    detect_count_next  = detect_count;
    mode               = MODE_PASS;
    handled            = 1'b0;
    pos_ext            = '0;

    case (item.operation)
      OP_START: begin
        if (phase == PH_BYPASS) begin
          phase_next         = PH_FADEOUT;
          complete_flag_next = 1'b0;
        end
      end
      OP_STOP: begin
        if (detect_active) begin
          detect_active_next = 1'b0;
          phase_next         = PH_FADEIN;
          complete_flag_next = 1'b1;
        end
      end
      OP_SAMPLE: begin
        if (detect_active) begin
          if (detect_count != '1) begin
            detect_count_next = detect_count + CNT_BITS'(1);
          end
          if (detect_count_next >= detect_limit) begin
            detect_active_next = 1'b0;
            phase_next         = PH_FADEIN;
            complete_flag_next = 1'b1;
          end
        end

        case (phase_next)
          PH_BYPASS, PH_FADEOUT, PH_PAUSE, PH_EMIT, PH_FADEIN: ;
          default: phase_next = PH_BYPASS;
        endcase

        if (phase_next == PH_FADEOUT) begin
          if (fade_down[FO_BITS-1] || (fade_down == '0)) begin
            gain_next       = '0;
            pause_left_next = pause_len;
            phase_next      = PH_PAUSE;
          end else begin
            gain_next = fade_down[SAMPLE_BITS-1:0];
            mode      = MODE_SCALE;
            handled   = 1'b1;
          end
        end

        if (!handled && (phase_next == PH_PAUSE)) begin
          if (pause_left_next != '0) begin
            mode            = MODE_ZERO;
            pause_left_next = pause_left_next - PAUSE_BITS'(1);
            handled         = 1'b1;
          end
          if (pause_left_next == '0) begin
            emit_pos_next      = '0;
            phase_next         = PH_EMIT;
            detect_active_next = 1'b1;
            detect_count_next  = '0;
          end
        end

        if (!handled && (phase_next == PH_EMIT)) begin
          pos_ext = EXT_BITS'(emit_pos_next);
          if (pos_ext < play_lim) begin
            mode          = MODE_TABLE;
            emit_pos_next = emit_pos_next + POS_BITS'(1);
          end else begin
            mode = MODE_ZERO;
          end
          handled = 1'b1;
        end

        if (!handled && (phase_next == PH_FADEIN)) begin
          if (fade_up >= FI_BITS'(UNITY_GAIN)) begin
            gain_next  = UNITY_GAIN;
            phase_next = PH_BYPASS;
          end else begin
            gain_next = fade_up[SAMPLE_BITS-1:0];
            mode      = MODE_SCALE;
          end
        end
      end
      default: ;
    endcase
  end

  assign tbl_re    = push && (mode == MODE_TABLE);
  assign tbl_raddr = pos_ext[AW-1:0];

  assign pipe.mode       = mode;
  assign pipe.sample     = item.sample_in;
  assign pipe.gain       = gain_next;
  assign pipe.out_phase  = PHASE_BITS'(phase_next);
  assign pipe.detecting  = detect_active_next;
  assign pipe.cycle_done = complete_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_step     <= FADE_STEP_RST;
      pause_len     <= PAUSE_LEN_RST;
      chirp_len     <= CHIRP_LEN_RST;
      detect_limit  <= DETECT_LIMIT_RST;
      phase         <= PH_BYPASS;
      detect_active <= 1'b0;
      complete_flag <= 1'b0;
      gain          <= UNITY_GAIN;
      pause_left    <= '0;
      emit_pos      <= '0;
      detect_count  <= '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_FADE_STEP:    fade_step    <= cfg_data[FADE_BITS-1:0];
          CFG_PAUSE_LEN:    pause_len    <= cfg_data[PAUSE_BITS-1:0];
          CFG_CHIRP_LEN:    chirp_len    <= cfg_data[LEN_BITS-1:0];
          CFG_DETECT_LIMIT: detect_limit <= cfg_data[CNT_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase         <= phase_next;
        detect_active <= detect_active_next;
        complete_flag <= complete_flag_next;
        gain          <= gain_next;
        pause_left    <= pause_left_next;
        emit_pos      <= emit_pos_next;
        detect_count  <= detect_count_next;
      end
    end
  end

  `CLPS_ASSERT_IMP(a_detect_in_emit, clk, rst, detect_active, phase == PH_EMIT, "detection outside emit")
  `CLPS_ASSERT_IMP(a_pause_muted, clk, rst, phase == PH_PAUSE, gain == '0, "gain not zero in pause")
  `CLPS_ASSERT_IMP(a_bypass_unity, clk, rst, phase == PH_BYPASS, gain == UNITY_GAIN, "bypass below unity")

endmodule

/* sv/clps_out_stage.sv */
// Output stage: table data join, gain multiply and the registered result beat.
`include "assert_macros.svh"

module clps_out_stage
  import clps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pipe_t                  pipe_in,
  input  logic [SAMPLE_BITS-1:0] rd_data,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data
);

  localparam int FRAC      = SAMPLE_BITS - 1;
  localparam int PROD_BITS = 2 * SAMPLE_BITS + 1;

  logic                          work_valid;
  pipe_t                         work;
  logic                          advance;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [SAMPLE_BITS-1:0] result;

  assign advance  = work_valid && (!out_valid || out_ready);
  assign in_ready = !work_valid || advance;

  // Arithmetic shift of the product is the floor of the scaled sample.
  assign prod = $signed(work.sample) * $signed({1'b0, work.gain});

  always_comb begin
    case (work.mode)
      MODE_PASS:  result = work.sample;
      MODE_SCALE: result = prod[SAMPLE_BITS-1+FRAC:FRAC];
      MODE_ZERO:  result = '0;
      MODE_TABLE: result = rd_data;
      default:    result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        work_valid <= 1'b1;
      end else if (advance) begin
        work_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (push) begin
      work <= pipe_in;
    end
    if (advance) begin
      out_data.sample_out <= result;
      out_data.out_phase  <= work.out_phase;
      out_data.detecting  <= work.detecting;
      out_data.cycle_done <= work.cycle_done;
    end
  end

  `CLPS_ASSERT_IMP(a_push_has_room, clk, rst, push, !work_valid || advance, "push over a held beat")
  `CLPS_ASSERT_NXT(a_stall_holds, clk, rst, work_valid && out_valid && !out_ready, work_valid && $stable(work), "held beat lost")

endmodule

/* sv/chirp_latency_probe_sequencer_top.sv */
// Top level of the chirp latency probe sequencer.
//
// Input channel (in_valid/in_ready/in_data) carries one op per beat: a sample,
// a start request, a chirp table load or an early stop. Only sample beats
// produce a result beat on the output channel (out_valid/out_ready/out_data);
// the other ops update state or the chirp table and produce nothing.
// The block takes one input beat per clock cycle while in_ready is high. A
// sample beat accepted at an edge is captured in the work register, and its
// chirp table read is issued in the accepting cycle and lands in the memory's
// output register at that edge; once the output register is free, the gain
// multiply is applied and the result is loaded into the output register.
// When the receiver stalls, the output register holds its beat and one more
// sample may wait behind it; in_ready drops only while both are occupied and
// out_ready is low.
// Synchronous reset returns the sequence to bypass at unity gain, clears
// detection and the done flag, and loads the configuration registers with
// their defaults. The chirp table is not cleared and has no clearing pass;
// it must be loaded before a measurement plays it.
// Configuration writes take effect at the edge where cfg_write_en is high
// and must be issued only while no beat is in flight.
module chirp_latency_probe_sequencer_top
  import clps_pkg::*;
#(
  parameter int CHIRP_DEPTH = CHIRP_DEPTH_DEF,
  localparam int AW = $clog2(CHIRP_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data
);

  logic                   accept;
  logic                   push;
  pipe_t                  pipe;
  logic                   tbl_we;
  logic [AW-1:0]          tbl_waddr;
  logic [SAMPLE_BITS-1:0] tbl_wdata;
  logic                   tbl_re;
  logic [AW-1:0]          tbl_raddr;
  logic [SAMPLE_BITS-1:0] tbl_rdata;

  assign accept = in_valid && in_ready;

  // Sequencer: every accepted beat updates the state at the accepting edge,
  // so the next beat already sees the result of this one.
  clps_ctrl #(
    .CHIRP_DEPTH(CHIRP_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .item        (in_data),
    .push        (push),
    .pipe        (pipe),
    .tbl_we      (tbl_we),
    .tbl_waddr   (tbl_waddr),
    .tbl_wdata   (tbl_wdata),
    .tbl_re      (tbl_re),
    .tbl_raddr   (tbl_raddr)
  );

  // A load and a playback read never fall in the same cycle, so a read that
  // follows a load of the same entry sees the new value without forwarding.
  clps_table #(
    .CHIRP_DEPTH(CHIRP_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re   (tbl_re),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  clps_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pipe_in  (pipe),
    .rd_data  (tbl_rdata),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
